/* src/frsc_pkg.sv */
`default_nettype none
package frsc_pkg;

	localparam int HeaderBytes = 40;
	localparam int CrcCover    = 36;
	localparam int MagicBytes  = 4;
	localparam int PosBits     = 25;
	localparam int CfgIdxBits  = 3;
	localparam int CfgDataBits = 64;
	localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;
	localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		KIND_RECORD  = 2'd0,
		KIND_ERROR   = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_MAGIC   = 3'd1,
		ERR_VERSION = 3'd2,
		ERR_TYPE    = 3'd3,
		ERR_HCRC    = 3'd4,
		ERR_LENGTH  = 3'd5,
		ERR_PCRC    = 3'd6,
		ERR_SEQ     = 3'd7
	} err_t;

	typedef enum logic [CfgIdxBits-1:0] {
		REG_MAGIC   = 3'd0,
		REG_VERSION = 3'd1,
		REG_TYPELIM = 3'd2,
		REG_MAXLEN  = 3'd3,
		REG_MINSEQ  = 3'd4
	} reg_idx_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* src/frsc_in_if.sv */
`default_nettype none
interface frsc_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;
	modport source (output valid, output command, output data_byte, input ready);
	modport sink   (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

/* src/frsc_out_if.sv */
`default_nettype none
interface frsc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [2:0]  fault_code;
	logic [15:0] record_type;
	logic [63:0] record_sequence;
	logic [23:0] body_len;
	logic        kept;
	logic [47:0] clean_bytes;
	logic        tail_cut;
	logic [24:0] tail_cut_bytes;
	logic        stream_failed;
	modport source (output valid, output result_kind, output fault_code, output record_type,
		output record_sequence, output body_len, output kept, output clean_bytes,
		output tail_cut, output tail_cut_bytes, output stream_failed, input ready);
	modport sink (input valid, input result_kind, input fault_code, input record_type,
		input record_sequence, input body_len, input kept, input clean_bytes,
		input tail_cut, input tail_cut_bytes, input stream_failed, output ready);
endinterface
`default_nettype wire

/* src/framed_record_stream_checker_unit.sv */
`default_nettype none
// Channel   Dir  Carries
// in_ch     in   command, data_byte (one stream byte or end of stream)
// out_ch    out  one result: record, error or end-of-stream summary
// cfg_*     in   register write: cfg_we, cfg_index, cfg_data
//
// One request per cycle; a result appears in the output register the
// cycle after its request is accepted (per-byte CRC is the longest path).
// in_ch.ready is low only while a held result is not yet taken.
// arst_n clears stream state and loads register reset values.
module framed_record_stream_checker_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	frsc_in_if.sink   in_ch,
	frsc_out_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic [frsc_pkg::CfgIdxBits-1:0]  cfg_index,
	input  wire logic [frsc_pkg::CfgDataBits-1:0] cfg_data
);
	import frsc_pkg::*;

	// configuration
	logic [31:0] magic_q;
	logic [15:0] version_q, typelim_q;
	logic [23:0] maxlen_q;
	logic [63:0] minseq_q;

	// stream state
	logic [PosBits-1:0] pos_q;
	logic [31:0] crc_q;
	logic [63:0] last_seq_q;
	logic [47:0] good_q;
	logic        failed_q;

	// captured header fields (only the bytes that are read back)
	logic [15:0] hver_q, htype_q;
	logic [63:0] hseq_q;
	logic [31:0] hlen_q, hpcrc_q;
	logic [23:0] hcrc_lo_q;

	// output register
	logic        ovalid_q;
	kind_t       kind_q;
	err_t        err_q;
	logic [15:0] otype_q;
	logic [63:0] oseq_q;
	logic [23:0] olen_q;
	logic        okept_q, otorn_q, ofail_q;
	logic [47:0] ogood_q;
	logic [24:0] otornb_q;

	logic accept;
	assign in_ch.ready = !ovalid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= '0;
			version_q <= 16'd1;
			typelim_q <= 16'd9;
			maxlen_q  <= 24'd65536;
			minseq_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAGIC:   magic_q   <= cfg_data[31:0];
				REG_VERSION: version_q <= cfg_data[15:0];
				REG_TYPELIM: typelim_q <= cfg_data[15:0];
				REG_MAXLEN:  maxlen_q  <= cfg_data[23:0];
				REG_MINSEQ:  minseq_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// next-state / result logic
	logic [7:0]  b;
	logic        in_hdr;
	logic [5:0]  hpos;
	logic [31:0] crc_upd;
	logic [PosBits-1:0] pos_inc;
	logic [PosBits-1:0] pos_n;
	logic [31:0] crc_n;
	logic [63:0] last_n;
	logic [47:0] good_n;
	logic        fail_n;
	logic        emit;
	kind_t       kind_n;
	err_t        err_n;
	logic [15:0] otype_n;
	logic [63:0] oseq_n;
	logic [23:0] olen_n;
	logic        okept_n, otorn_n, ofail_n;
	logic [47:0] ogood_n;
	logic [24:0] otornb_n;
	logic        do_finish;
	logic [31:0] crc_fin;
	logic [31:0] hcrc_full;
	logic [PosBits-1:0] paid;

	assign b       = in_ch.data_byte;
	assign in_hdr  = (pos_q < PosBits'(HeaderBytes));
	assign hpos    = pos_q[5:0];
	assign crc_upd = crc_byte(crc_q, b);
	assign pos_inc = pos_q + 1'b1;
	assign hcrc_full = {b, hcrc_lo_q};
	assign paid    = pos_q - PosBits'(HeaderBytes - 1);

	always_comb begin
		pos_n = pos_q; crc_n = crc_q; last_n = last_seq_q; good_n = good_q;
		fail_n = failed_q;
		emit = 1'b0; kind_n = KIND_RECORD; err_n = ERR_NONE;
		otype_n = '0; oseq_n = '0; olen_n = '0; okept_n = 1'b0;
		otorn_n = 1'b0; otornb_n = '0; ofail_n = 1'b0; ogood_n = good_q;
		do_finish = 1'b0; crc_fin = AllOnes;
		if (in_ch.command) begin
			emit = 1'b1; kind_n = KIND_SUMMARY;
			ofail_n = failed_q;
			otorn_n = !failed_q && (pos_q != '0);
			otornb_n = otorn_n ? pos_q : '0;
			pos_n = '0; crc_n = AllOnes; last_n = '0; good_n = '0; fail_n = 1'b0;
		end else if (!failed_q) begin
			if (in_hdr) begin
				pos_n = pos_inc;
				if (hpos < 6'(CrcCover)) begin
					crc_n = (hpos == 6'(CrcCover - 1)) ? ~crc_upd : crc_upd;
				end
				if (hpos < 6'(MagicBytes) && b != magic_q[8*hpos[1:0] +: 8]) begin
					emit = 1'b1; kind_n = KIND_ERROR; err_n = ERR_MAGIC; fail_n = 1'b1;
				end else if (hpos == 6'(HeaderBytes - 1)) begin
					oseq_n = hseq_q;
					if (hver_q != version_q) begin
						emit = 1'b1; kind_n = KIND_ERROR; err_n = ERR_VERSION; fail_n = 1'b1;
					end else if (htype_q == '0 || htype_q >= typelim_q) begin
						emit = 1'b1; kind_n = KIND_ERROR; err_n = ERR_TYPE; fail_n = 1'b1;
					end else if (hcrc_full != crc_q) begin
						emit = 1'b1; kind_n = KIND_ERROR; err_n = ERR_HCRC; fail_n = 1'b1;
					end else if (hlen_q[31:24] != '0 || hlen_q[23:0] > maxlen_q) begin
						emit = 1'b1; kind_n = KIND_ERROR; err_n = ERR_LENGTH; fail_n = 1'b1;
					end else begin
						crc_n = AllOnes;
						if (hlen_q == '0) begin
							do_finish = 1'b1; crc_fin = AllOnes;
						end
					end
				end
			end else begin
				crc_n = crc_upd; pos_n = pos_inc;
				if ({7'd0, paid} >= hlen_q) begin
					do_finish = 1'b1; crc_fin = crc_upd;
				end
			end
			if (do_finish) begin
				emit = 1'b1; oseq_n = hseq_q;
				if (~crc_fin != hpcrc_q) begin
					kind_n = KIND_ERROR; err_n = ERR_PCRC; fail_n = 1'b1;
				end else if (last_seq_q != '0 && hseq_q <= last_seq_q) begin
					kind_n = KIND_ERROR; err_n = ERR_SEQ; fail_n = 1'b1;
				end else begin
					kind_n = KIND_RECORD; otype_n = htype_q; olen_n = hlen_q[23:0];
					okept_n = hseq_q > minseq_q;
					last_n = hseq_q;
					good_n = good_q + 48'(pos_inc);
					ogood_n = good_n;   // count includes the record just closed
					pos_n = '0; crc_n = AllOnes;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; crc_q <= AllOnes; last_seq_q <= '0; good_q <= '0; failed_q <= 1'b0;
		end else if (accept) begin
			pos_q <= pos_n; crc_q <= crc_n; last_seq_q <= last_n; good_q <= good_n;
			failed_q <= fail_n;
		end
	end

	// header field capture, by byte position
	always_ff @(posedge clk) begin
		if (accept && !in_ch.command && !failed_q && in_hdr) begin
			if (hpos >= 6'd4 && hpos <= 6'd5)   hver_q[8*hpos[0] +: 8]      <= b;
			if (hpos >= 6'd6 && hpos <= 6'd7)   htype_q[8*hpos[0] +: 8]     <= b;
			if (hpos >= 6'd12 && hpos <= 6'd19) hseq_q[8*(3'(hpos - 6'd12)) +: 8] <= b;
			if (hpos >= 6'd28 && hpos <= 6'd31) hlen_q[8*hpos[1:0] +: 8]    <= b;
			if (hpos >= 6'd32 && hpos <= 6'd35) hpcrc_q[8*hpos[1:0] +: 8]   <= b;
			if (hpos >= 6'd36 && hpos <= 6'd38) hcrc_lo_q[8*hpos[1:0] +: 8] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (accept) begin
			ovalid_q <= emit;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_q <= kind_n; err_q <= err_n; otype_q <= otype_n; oseq_q <= oseq_n;
			olen_q <= olen_n; okept_q <= okept_n; ogood_q <= ogood_n; otorn_q <= otorn_n;
			otornb_q <= otornb_n; ofail_q <= ofail_n;
		end
	end

	assign out_ch.valid           = ovalid_q;
	assign out_ch.result_kind     = kind_q;
	assign out_ch.fault_code      = err_q;
	assign out_ch.record_type     = otype_q;
	assign out_ch.record_sequence = oseq_q;
	assign out_ch.body_len        = olen_q;
	assign out_ch.kept            = okept_q;
	assign out_ch.clean_bytes     = ogood_q;
	assign out_ch.tail_cut        = otorn_q;
	assign out_ch.tail_cut_bytes  = otornb_q;
	assign out_ch.stream_failed   = ofail_q;

	// error results always carry a code
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && kind_q == KIND_ERROR |-> err_q != ERR_NONE)
		else $error("error result without code");
	// a torn tail is never reported on a failed stream
	a_torn: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && kind_q == KIND_SUMMARY && otorn_q |-> !ofail_q && otornb_q != '0)
		else $error("torn tail inconsistent");
	// end of stream clears stream state
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.command |=> pos_q == '0 && !failed_q && good_q == '0)
		else $error("stream state not cleared");
	// an error sets the failed latch
	a_latch: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit && kind_n == KIND_ERROR |=> failed_q)
		else $error("failed latch not set");

endmodule
`default_nettype wire

/* sim/frsc_scoreboard.sv */
class frsc_scoreboard;
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [2:0]  fault_code;
		logic [15:0] record_type;
		logic [63:0] record_sequence;
		logic [23:0] body_len;
		logic        kept;
		logic [47:0] clean_bytes;
		logic        tail_cut;
		logic [24:0] tail_cut_bytes;
		logic        stream_failed;
	} verdict_t;

	// register copies
	logic [31:0] magic_word;
	logic [15:0] version_ok;
	logic [15:0] type_lim;
	logic [23:0] max_len;
	logic [63:0] min_seq;

	// stream state
	int unsigned  rec_pos;
	logic [7:0]   hdr [40];
	logic [31:0]  crc;
	logic [63:0]  last_seq;
	logic [47:0]  good_cnt;
	bit           failed;

	verdict_t pending_verdicts[$];
	int       errors;

	function new();
		magic_word = '0;
		version_ok = 16'd1;
		type_lim = 16'd9;
		max_len = 24'd65536;
		min_seq = '0;
		errors = 0;
		clear_stream();
	endfunction

	function void clear_stream();
		rec_pos = 0;
		crc = 32'hFFFF_FFFF;
		last_seq = '0;
		good_cnt = '0;
		failed = 0;
	endfunction

	function void write_reg(frsc_pkg::reg_idx_t idx, logic [63:0] v);
		case (idx)
			frsc_pkg::REG_MAGIC:   magic_word = v[31:0];
			frsc_pkg::REG_VERSION: version_ok = v[15:0];
			frsc_pkg::REG_TYPELIM: type_lim = v[15:0];
			frsc_pkg::REG_MAXLEN:  max_len = v[23:0];
			frsc_pkg::REG_MINSEQ:  min_seq = v;
			default: ;
		endcase
	endfunction

	function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
		c ^= {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
		return c;
	endfunction

	function logic [63:0] field_le(int at, int n);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < n; i++)
			v |= 64'(hdr[at + i]) << (8 * i);
		return v;
	endfunction

	function void push_fail(frsc_pkg::err_t e, logic [63:0] s);
		verdict_t r;
		r = '0;
		r.result_kind = frsc_pkg::KIND_ERROR;
		r.fault_code = e;
		r.record_sequence = s;
		r.clean_bytes = good_cnt;
		failed = 1;
		pending_verdicts.insert(pending_verdicts.size(), r);
	endfunction

	function void close_record();
		verdict_t r;
		logic [63:0] s;
		s = field_le(12, 8);
		if ((crc ^ 32'hFFFF_FFFF) != field_le(32, 4)) begin
			push_fail(frsc_pkg::ERR_PCRC, s);
			return;
		end
		if (last_seq != 0 && s <= last_seq) begin
			push_fail(frsc_pkg::ERR_SEQ, s);
			return;
		end
		last_seq = s;
		good_cnt = good_cnt + 48'(rec_pos);
		rec_pos = 0;
		crc = 32'hFFFF_FFFF;
		r = '0;
		r.result_kind = frsc_pkg::KIND_RECORD;
		r.fault_code = frsc_pkg::ERR_NONE;
		r.record_type = 16'(field_le(6, 2));
		r.record_sequence = s;
		r.body_len = 24'(field_le(28, 4));
		r.kept = s > min_seq;
		r.clean_bytes = good_cnt;
		pending_verdicts.insert(pending_verdicts.size(), r);
	endfunction

	// accepted request
	function void note_request(logic cmd, logic [7:0] b);
		verdict_t r;
		logic [63:0] len, typ, seq;
		if (cmd) begin
			r = '0;
			r.result_kind = frsc_pkg::KIND_SUMMARY;
			r.clean_bytes = good_cnt;
			r.tail_cut = !failed && rec_pos > 0;
			r.tail_cut_bytes = r.tail_cut ? 25'(rec_pos) : '0;
			r.stream_failed = failed;
			pending_verdicts.insert(pending_verdicts.size(), r);
			clear_stream();
			return;
		end
		if (failed)
			return;
		if (rec_pos < 40) begin
			hdr[rec_pos] = b;
			if (rec_pos < 4 && b != magic_word[8*rec_pos +: 8]) begin
				push_fail(frsc_pkg::ERR_MAGIC, '0);
				return;
			end
			if (rec_pos < 36) begin
				crc = crc_update(crc, b);
				if (rec_pos == 35)
					crc ^= 32'hFFFF_FFFF;
			end
			rec_pos++;
			if (rec_pos < 40)
				return;
			typ = field_le(6, 2);
			seq = field_le(12, 8);
			len = field_le(28, 4);
			if (field_le(4, 2) != 64'(version_ok))
				push_fail(frsc_pkg::ERR_VERSION, seq);
			else if (typ == 0 || typ >= 64'(type_lim))
				push_fail(frsc_pkg::ERR_TYPE, seq);
			else if (field_le(36, 4) != 64'(crc))
				push_fail(frsc_pkg::ERR_HCRC, seq);
			else if (len > 64'(max_len))
				push_fail(frsc_pkg::ERR_LENGTH, seq);
			else begin
				crc = 32'hFFFF_FFFF;
				if (len == 0)
					close_record();
			end
			return;
		end
		crc = crc_update(crc, b);
		rec_pos++;
		if (64'(rec_pos - 40) >= field_le(28, 4))
			close_record();
	endfunction

	function void check_result(verdict_t got);
		verdict_t w;
		if (pending_verdicts.size() == 0) begin
			$error("unexpected result kind=%0d", got.result_kind);
			errors++;
			return;
		end
		w = pending_verdicts.pop_front();
		if (w.result_kind != got.result_kind) begin
			$error("result_kind exp %0d got %0d", w.result_kind, got.result_kind); errors++;
		end
		if (w.fault_code != got.fault_code) begin
			$error("fault_code exp %0d got %0d", w.fault_code, got.fault_code); errors++;
		end
		if (w.record_type != got.record_type) begin
			$error("record_type exp %0h got %0h", w.record_type, got.record_type); errors++;
		end
		if (w.record_sequence != got.record_sequence) begin
			$error("record_sequence exp %0h got %0h", w.record_sequence,
				got.record_sequence); errors++;
		end
		if (w.body_len != got.body_len) begin
			$error("body_len exp %0d got %0d", w.body_len,
				got.body_len); errors++;
		end
		if (w.kept != got.kept) begin
			$error("kept exp %0d got %0d", w.kept, got.kept); errors++;
		end
		if (w.clean_bytes != got.clean_bytes) begin
			$error("clean_bytes exp %0d got %0d", w.clean_bytes, got.clean_bytes); errors++;
		end
		if (w.tail_cut != got.tail_cut) begin
			$error("tail_cut exp %0d got %0d", w.tail_cut, got.tail_cut); errors++;
		end
		if (w.tail_cut_bytes != got.tail_cut_bytes) begin
			$error("tail_cut_bytes exp %0d got %0d", w.tail_cut_bytes,
				got.tail_cut_bytes); errors++;
		end
		if (w.stream_failed != got.stream_failed) begin
			$error("stream_failed exp %0d got %0d", w.stream_failed,
				got.stream_failed); errors++;
		end
	endfunction
endclass

/* sim/framed_record_stream_checker_unit_tb.sv */
module framed_record_stream_checker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import frsc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CfgIdxBits-1:0] cfg_index = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;

	frsc_in_if  in_ch();
	frsc_out_if out_ch();

	framed_record_stream_checker_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	frsc_scoreboard journal_model = new();
	int  requests_sent;
	bit  quiet_tail;    // no idling near the end
	bit  sink_stall_on;

	// byte staging for one record
	logic [7:0] rec_bytes[$];

	initial begin
		in_ch.valid = 0;
		in_ch.command = 0;
		in_ch.data_byte = '0;
		out_ch.ready = 0;
	end

	// result side: random stall bursts, check each taken result
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			journal_model.check_result({out_ch.result_kind, out_ch.fault_code,
				out_ch.record_type, out_ch.record_sequence, out_ch.body_len,
				out_ch.kept, out_ch.clean_bytes, out_ch.tail_cut,
				out_ch.tail_cut_bytes, out_ch.stream_failed});
	end

	initial begin : sink_proc
		int n;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (!quiet_tail && sink_stall_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 15);
				out_ch.ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1;
			@(posedge clk);
		end
	end

	// one request; may leave valid high for the next call
	task automatic send_request(logic cmd, logic [7:0] b);
		int n;
		if (!quiet_tail && $urandom_range(0, 15) == 0) begin
			n = $urandom_range(1, 15);
			in_ch.valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.command <= cmd;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		journal_model.note_request(cmd, b);
		requests_sent++;
	endtask

	task automatic go_idle();
		in_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		while (journal_model.pending_verdicts.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		journal_model.write_reg(idx, v);
		@(posedge clk);
	endtask

	function automatic logic [31:0] crc_of_bytes(int from, int n);
		logic [31:0] c;
		c = 32'hFFFF_FFFF;
		for (int i = from; i < from + n; i++)
			c = journal_model.crc_update(c, rec_bytes[i]);
		return c ^ 32'hFFFF_FFFF;
	endfunction

	// build a well-formed record into rec_bytes; flaw selects a defect
	typedef enum int {
		FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_TYPE, FLAW_HCRC,
		FLAW_LENGTH, FLAW_PCRC
	} flaw_t;

	task automatic build_record(logic [15:0] rtype, logic [63:0] seq, int len,
		flaw_t flaw);
		logic [31:0] hc, pc;
		logic [15:0] ver;
		int tl;
		rec_bytes.delete();
		ver = journal_model.version_ok;
		if (flaw == FLAW_VERSION) ver = ver ^ 16'(1 << $urandom_range(0, 15));
		for (int i = 0; i < 40; i++) rec_bytes.insert(rec_bytes.size(), 8'($urandom));
		for (int i = 0; i < 4; i++) rec_bytes[i] = journal_model.magic_word[8*i +: 8];
		if (flaw == FLAW_MAGIC) begin
			tl = $urandom_range(0, 3);
			rec_bytes[tl] = rec_bytes[tl] ^ 8'(1 << $urandom_range(0, 7));
		end
		rec_bytes[4] = ver[7:0]; rec_bytes[5] = ver[15:8];
		rec_bytes[6] = rtype[7:0]; rec_bytes[7] = rtype[15:8];
		for (int i = 0; i < 8; i++) rec_bytes[12 + i] = seq[8*i +: 8];
		for (int i = 0; i < 4; i++) rec_bytes[28 + i] = 8'(len >> (8 * i));
		for (int i = 0; i < len; i++) rec_bytes.insert(rec_bytes.size(), 8'($urandom));
		pc = crc_of_bytes(40, len);
		if (flaw == FLAW_PCRC) pc = pc ^ 32'(1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++) rec_bytes[32 + i] = pc[8*i +: 8];
		hc = crc_of_bytes(0, 36);
		if (flaw == FLAW_HCRC) hc = hc ^ 32'(1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++) rec_bytes[36 + i] = hc[8*i +: 8];
	endtask

	task automatic send_record(int upto);
		for (int i = 0; i < rec_bytes.size() && i < upto; i++)
			send_request(1'b0, rec_bytes[i]);
	endtask

	// random well-formed stream with occasional defects and torn tails
	task automatic random_stream(int n_records, logic [63:0] seq_step);
		logic [63:0] seq;
		int len, pick, typ;
		flaw_t flaw;
		seq = 64'($urandom_range(0, 3));
		for (int r = 0; r < n_records; r++) begin
			pick = $urandom_range(0, 19);
			flaw = FLAW_NONE;
			if (pick == 0) flaw = FLAW_MAGIC;
			else if (pick == 1) flaw = FLAW_VERSION;
			else if (pick == 2) flaw = FLAW_HCRC;
			else if (pick == 3) flaw = FLAW_PCRC;
			len = ($urandom_range(0, 30) == 0) ? $urandom_range(40, 200)
				: $urandom_range(0, 12);
			if (len > journal_model.max_len) len = journal_model.max_len;
			typ = $urandom_range(1, journal_model.type_lim - 1);
			if (pick == 4) typ = journal_model.type_lim + $urandom_range(0, 1);
			if (pick == 5) typ = 0;
			if (pick == 6) seq = seq - 64'($urandom_range(0, 1)); // non-rising
			else seq = seq + 64'($urandom_range(1, 3)) * seq_step;
			build_record(16'(typ), seq, len, flaw);
			if (pick == 7)
				send_record($urandom_range(1, rec_bytes.size() - 1)); // torn
			else
				send_record(rec_bytes.size());
			if (pick == 7 || pick == 8 || journal_model.failed) begin
				if (pick == 8 && !journal_model.failed) send_request(1'b0, 8'($urandom));
				send_request(1'b1, 8'($urandom));
				seq = 64'($urandom_range(0, 3));
			end
		end
		send_request(1'b1, 8'h00);
	endtask

	initial begin : stimulus
		logic [63:0] v;
		requests_sent = 0;
		quiet_tail = 0;
		sink_stall_on = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, magic zero
		build_record(16'd1, 64'd0, 0, FLAW_NONE);
		send_record(40);                         // zero-length record, sequence zero
		build_record(16'd8, 64'd0, 3, FLAW_NONE);
		send_record(43);                         // zero seq again passes
		build_record(16'd2, 64'd5, 1, FLAW_NONE);
		send_record(41);
		build_record(16'd2, 64'd5, 1, FLAW_NONE);
		send_record(41);                         // repeated sequence
		send_request(1'b1, 8'hFF);               // summary after failure
		send_request(1'b1, 8'h00);               // empty stream
		build_record(16'd3, 64'd9, 2, FLAW_NONE);
		send_record(20);                         // torn tail
		send_request(1'b1, 8'h00);
		build_record(16'd9, 64'd1, 0, FLAW_NONE);
		send_record(40);                         // type at limit
		send_request(1'b1, 8'h00);
		go_idle();
		drain_results();

		// extremes of the registers
		write_reg(REG_MAGIC, 64'hFFFF_FFFF);
		write_reg(REG_VERSION, 64'hFFFF);
		write_reg(REG_TYPELIM, 64'hFFFF);
		write_reg(REG_MAXLEN, 64'hFF_FFFF);
		write_reg(REG_MINSEQ, 64'hFFFF_FFFF_FFFF_FFFE);
		build_record(16'hFFFE, 64'hFFFF_FFFF_FFFF_FFFF, 2, FLAW_NONE);
		send_record(42);
		send_request(1'b1, 8'h00);
		build_record(16'h0001, 64'h1, 0, FLAW_NONE);
		for (int i = 28; i < 32; i++) rec_bytes[i] = 8'hFF;  // length over cap
		rec_bytes.delete(36); rec_bytes.delete(36); rec_bytes.delete(36);
		rec_bytes.delete(36);
		v = {32'd0, crc_of_bytes(0, 36)};
		for (int i = 0; i < 4; i++) rec_bytes.insert(36 + i, v[8*i +: 8]);
		send_record(40);
		send_request(1'b1, 8'h00);
		go_idle();
		drain_results();
		write_reg(REG_TYPELIM, 64'd1);            // every type rejected
		write_reg(REG_MAXLEN, 64'd0);
		build_record(16'd1, 64'd3, 0, FLAW_NONE);
		send_record(40);
		send_request(1'b1, 8'h00);
		go_idle();
		drain_results();

		// random phases over several settings
		for (int ph = 0; ph < 5; ph++) begin
			go_idle();   // registers change only with nothing in flight
			drain_results();
			write_reg(REG_MAGIC, 64'($urandom));
			write_reg(REG_VERSION, 64'($urandom_range(0, 65535)));
			write_reg(REG_TYPELIM, 64'($urandom_range(2, 12)));
			write_reg(REG_MAXLEN, (ph == 2) ? 64'd5 : 64'($urandom_range(12, 300)));
			write_reg(REG_MINSEQ, 64'($urandom_range(0, 20)));
			if (ph == 4 || requests_sent > 1150) quiet_tail = 1;
			random_stream(9, 64'd1);
			if (ph == 1) begin
				go_idle();   // hold off until all results are in
				drain_results();
			end
			if (requests_sent > 1550) break;
		end
		quiet_tail = 1;
		while (requests_sent < 1550) random_stream(4, 64'd1);
		go_idle();
		drain_results();
		repeat (10) @(posedge clk);
		if (journal_model.errors == 0 && journal_model.pending_verdicts.size() == 0)
			$display("framed_record_stream_checker_unit_tb passed");
		else
			$display("framed_record_stream_checker_unit_tb failed");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("framed_record_stream_checker_unit_tb failed");
		$finish;
	end
endmodule
